### hw/rtl/fqrs_pkg.sv
// Command and status codes used by the queue core.
package fqrs_pkg;

	typedef enum logic [2:0] {
		CMD_ENQUEUE = 3'd0,
		CMD_DEQUEUE = 3'd1,
		CMD_PEEK    = 3'd2,
		CMD_COUNT   = 3'd3,
		CMD_CLEAR   = 3'd4,
		CMD_REVERSE = 3'd5,
		CMD_FIND    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

endpackage

### hw/rtl/fqrs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module fqrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/fifo_queue_with_reverse_and_search_core.sv
// Bounded FIFO of signed words with reverse and find commands.
//
// Input channel: in_valid/in_stall carry one command and an operand per transfer.
// Output channel: out_valid/out_stall carry exactly one result per command:
// the dequeued or peeked word, the find position, the occupancy afterwards and
// a status code.
// A command is taken only while the sequencer is idle. Enqueue, count, clear,
// reverse and any command on an empty queue go from the transfer straight to
// the done state. Dequeue and peek first pass the scan state, as the ring
// store has a registered read port. Find walks the ring one slot per cycle
// through that same port until the match or the last element. Without output
// stalls the next command is taken at the edge where the result leaves.
// The output register holds one finished result, so the next command is
// taken while that result waits; if the receiver keeps stalling, the next
// result waits in the sequencer and no further command is taken.
// Reset empties the queue and restores normal order; the ring store itself
// is not cleared and needs no clearing pass.
module fifo_queue_with_reverse_and_search_core
	import fqrs_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     command,
	input  logic signed [DATA_WIDTH-1:0]   operand,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [DATA_WIDTH-1:0]   word,
	output logic [$clog2(DEPTH+1)-1:0]     position,
	output logic [$clog2(DEPTH+1)-1:0]     occupancy,
	output logic [1:0]                     status
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(DEPTH);
	localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [ADDR_W-1:0]       head_q;
	logic [CNT_W-1:0]        count_q;
	logic                    rev_q;
	logic [2:0]              cmd_q;
	logic [DATA_WIDTH-1:0]   key_q;
	logic [ADDR_W-1:0]       ptr_q;
	logic [CNT_W-1:0]        idx_q;
	logic [DATA_WIDTH-1:0]   res_word_q;
	logic [CNT_W-1:0]        res_pos_q;
	status_t                 res_status_q;
	logic                    out_valid_q;
	logic [DATA_WIDTH-1:0]   word_q;
	logic [CNT_W-1:0]        position_q;
	logic [CNT_W-1:0]        occupancy_q;
	status_t                 status_q;

	logic                    accept;
	logic                    is_empty;
	logic                    is_full;
	logic [SUM_W-1:0]        tail_sum;
	logic [SUM_W-1:0]        last_sum;
	logic [ADDR_W-1:0]       tail_addr;
	logic [ADDR_W-1:0]       last_addr;
	logic [ADDR_W-1:0]       front_addr;
	logic [ADDR_W-1:0]       head_dec;
	logic [ADDR_W-1:0]       head_inc;
	logic [ADDR_W-1:0]       scan_from;
	logic [ADDR_W-1:0]       scan_next;
	logic [CNT_W-1:0]        idx_inc;
	logic                    out_free;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic                    ram_re;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [DATA_WIDTH-1:0]   ram_rdata;

	function automatic logic [ADDR_W-1:0] step_up(input logic [ADDR_W-1:0] a);
		return (a == LAST_A) ? '0 : ADDR_W'(a + 1'b1);
	endfunction

	function automatic logic [ADDR_W-1:0] step_down(input logic [ADDR_W-1:0] a);
		return (a == '0) ? LAST_A : ADDR_W'(a - 1'b1);
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == DEPTH_C);
	assign out_free = !out_valid_q || !out_stall;

	// Both sums are under twice the depth unless empty; a conditional subtract wraps them.
	always_comb begin
		tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
		last_sum  = tail_sum - 1'b1;
		tail_addr = (tail_sum >= DEPTH_S) ? ADDR_W'(tail_sum - DEPTH_S) : ADDR_W'(tail_sum);
		last_addr = (last_sum >= DEPTH_S) ? ADDR_W'(last_sum - DEPTH_S) : ADDR_W'(last_sum);
		head_dec  = step_down(head_q);
		head_inc  = step_up(head_q);
		front_addr = rev_q ? last_addr : head_q;
		scan_from  = rev_q ? step_down(front_addr) : step_up(front_addr);
		scan_next  = rev_q ? step_down(ptr_q) : step_up(ptr_q);
		idx_inc    = idx_q + 1'b1;
	end

	assign ram_we    = accept && (command == CMD_ENQUEUE) && !is_full;
	assign ram_waddr = rev_q ? head_dec : tail_addr;
	assign ram_re    = accept || (state_q == S_SCAN);
	assign ram_raddr = (state_q == S_IDLE) ? front_addr : ptr_q;

	fqrs_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (operand),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In the done state the output register is reloaded below instead.
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= command;
						key_q        <= operand;
						res_word_q   <= '0;
						res_pos_q    <= '0;
						res_status_q <= ST_OK;
						idx_q        <= '0;
						ptr_q        <= scan_from;
						state_q      <= S_DONE;
						case (command)
							CMD_ENQUEUE: begin
								if (is_full) begin
									res_status_q <= ST_FULL;
								end else begin
									if (rev_q) begin
										head_q <= head_dec;
									end
									count_q <= count_q + 1'b1;
								end
							end
							CMD_DEQUEUE, CMD_PEEK, CMD_FIND: begin
								// The front slot is being read; the scan state picks it up.
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_CLEAR: begin
								head_q  <= '0;
								count_q <= '0;
								rev_q   <= 1'b0;
							end
							CMD_REVERSE: begin
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									rev_q <= !rev_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (cmd_q == CMD_FIND) begin
						if (ram_rdata == key_q) begin
							res_pos_q <= idx_inc;
							state_q   <= S_DONE;
						end else if (idx_inc == count_q) begin
							res_status_q <= ST_NOTFOUND;
							state_q      <= S_DONE;
						end else begin
							idx_q <= idx_inc;
							ptr_q <= scan_next;
						end
					end else begin
						res_word_q <= ram_rdata;
						if (cmd_q == CMD_DEQUEUE) begin
							if (!rev_q) begin
								head_q <= head_inc;
							end
							count_q <= count_q - 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						word_q      <= res_word_q;
						position_q  <= res_pos_q;
						occupancy_q <= count_q;
						status_q    <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign position  = position_q;
	assign occupancy = occupancy_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("occupancy exceeds the depth");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0) && (idx_q < count_q))
		else $error("ring scan on an empty queue or past the last element");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE) && (count_q < DEPTH_C))
		else $error("ring write outside an accepted enqueue");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_FULL)) |-> (occupancy_q == DEPTH_C))
		else $error("full status reported on a queue that was not full");

	a_pos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (position_q != '0)) |-> (status_q == ST_OK))
		else $error("find position given without ok status");
`endif

endmodule
